// ===== rtl/core/rdec_pkg.sv =====
// Package for the recent-id de-duplicating event counter.
// Holds list depth, event and register codes, sequencer states and payload structs.
// No dependencies.
`default_nettype none

package rdec_pkg;

	localparam int LIST_DEPTH = 8;
	localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int ID_W       = 32;
	localparam int CNT_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [1:0] MODE_TRADE   = 2'd0;
	localparam logic [1:0] MODE_WIN     = 2'd1;
	localparam logic [1:0] MODE_LOSS    = 2'd2;
	localparam logic [1:0] MODE_INVALID = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_STATS_EN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CARD_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STAT_LIMIT = 2'd2;

	localparam logic [CNT_W-1:0] STAT_LIMIT_RST = 16'd999;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_UPDATE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]      mode;
		logic [ID_W-1:0] partner_id;
	} evt_t;

	typedef struct packed {
		logic             is_new;
		logic             counted;
		logic [CNT_W-1:0] win_total;
		logic [CNT_W-1:0] loss_total;
		logic [CNT_W-1:0] trade_total;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/core/recent_id_dedup_event_counter.sv =====
// Top level: move-to-front recency lists with a shared id comparator; depends on rdec_pkg.
// An ignored event goes from idle straight to done; a used event passes search, update and
// done; one compare per cycle walks the selected list until a hit or the last slot.
// An event is taken only when the last is done: input stalls while an event is in work.
// The result register holds a finished result until taken while the next event is taken.
// Reset (arst_n low, asynchronous): lists and counters clear to zero, limit to 999.
`default_nettype none

module recent_id_dedup_event_counter (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               evt_valid,
	output logic                                    evt_stall,
	input  wire rdec_pkg::evt_t                     evt,
	output logic                                    res_valid,
	input  wire logic                               res_stall,
	output rdec_pkg::res_t                          res,
	input  wire logic                               cfg_we,
	input  wire logic [rdec_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [rdec_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rdec_pkg::*;

	state_t            state_q, state_d;
	logic [1:0]        mode_q;
	logic [ID_W-1:0]   id_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  pos_q;
	logic              miss_q;
	logic              active_q;
	logic              stats_en_q, card_count_q;
	logic [CNT_W-1:0]  limit_q;
	logic [CNT_W-1:0]  win_cnt_q, loss_cnt_q, trade_cnt_q;
	logic [ID_W-1:0]   trade_ids_q  [LIST_DEPTH];
	logic [ID_W-1:0]   battle_ids_q [LIST_DEPTH];
	logic              res_valid_q;
	res_t              res_q;

	logic              evt_xfer, evt_used, at_last, hit;
	logic              res_load, res_free;
	logic [ID_W-1:0]   cur_id;
	logic [CNT_W-1:0]  sel_cnt, bump_val;
	logic [CNT_W:0]    bump_sum;

	assign evt_xfer = evt_valid && !evt_stall;
	assign evt_used = stats_en_q && (evt.mode != MODE_INVALID);
	assign at_last  = (idx_q == IDX_W'(LIST_DEPTH - 1));
	assign cur_id   = (mode_q == MODE_TRADE) ? trade_ids_q[idx_q] : battle_ids_q[idx_q];
	assign hit      = (cur_id == id_q);
	assign res_free = !res_valid_q || !res_stall;

	always_comb begin
		case (mode_q)
			MODE_TRADE: sel_cnt = trade_cnt_q;
			MODE_WIN:   sel_cnt = win_cnt_q;
			default:    sel_cnt = loss_cnt_q;
		endcase
		bump_sum = {1'b0, sel_cnt} + (CNT_W+1)'(1);
		bump_val = (bump_sum > {1'b0, limit_q}) ? limit_q : bump_sum[CNT_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (evt_xfer) state_d = evt_used ? ST_SEARCH : ST_DONE;
			end
			ST_SEARCH: begin
				if (hit || at_last) state_d = ST_UPDATE;
			end
			ST_UPDATE: state_d = ST_DONE;
			ST_DONE: begin
				if (res_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		evt_stall = (state_q != ST_IDLE);
		res_load  = (state_q == ST_DONE) && res_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			pos_q       <= '0;
			miss_q      <= 1'b0;
			active_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (evt_xfer) begin
				idx_q    <= '0;
				miss_q   <= 1'b0;
				active_q <= evt_used;
			end
			if (state_q == ST_SEARCH) begin
				if (hit) begin
					pos_q <= idx_q;
				end else if (at_last) begin
					pos_q  <= idx_q;
					miss_q <= 1'b1;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			if (res_load) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_xfer) begin
			mode_q <= evt.mode;
			id_q   <= evt.partner_id;
		end
		if (res_load) begin
			res_q.is_new      <= active_q && miss_q;
			res_q.counted     <= active_q && miss_q && card_count_q;
			res_q.win_total   <= win_cnt_q;
			res_q.loss_total  <= loss_cnt_q;
			res_q.trade_total <= trade_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stats_en_q   <= 1'b0;
			card_count_q <= 1'b0;
			limit_q      <= STAT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_STATS_EN:   stats_en_q   <= cfg_data[0];
				REG_CARD_COUNT: card_count_q <= cfg_data[0];
				REG_STAT_LIMIT: limit_q      <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_cnt_q   <= '0;
			loss_cnt_q  <= '0;
			trade_cnt_q <= '0;
			for (int k = 0; k < LIST_DEPTH; k++) begin
				trade_ids_q[k]  <= '0;
				battle_ids_q[k] <= '0;
			end
		end else if (state_q == ST_UPDATE) begin
			for (int k = 0; k < LIST_DEPTH; k++) begin
				if (k == 0) begin
					if (mode_q == MODE_TRADE) trade_ids_q[0] <= id_q;
					else battle_ids_q[0] <= id_q;
				end else if (IDX_W'(k) <= pos_q) begin
					if (mode_q == MODE_TRADE) trade_ids_q[k] <= trade_ids_q[k-1];
					else battle_ids_q[k] <= battle_ids_q[k-1];
				end
			end
			if (miss_q && card_count_q) begin
				case (mode_q)
					MODE_TRADE: trade_cnt_q <= bump_val;
					MODE_WIN:   win_cnt_q   <= bump_val;
					default:    loss_cnt_q  <= bump_val;
				endcase
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTH
	a_cnt_only_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		(trade_cnt_q != $past(trade_cnt_q)) || (win_cnt_q != $past(win_cnt_q))
		|-> $past(state_q == ST_UPDATE))
		else $error("counter changed outside update step");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (idx_q <= IDX_W'(LIST_DEPTH - 1)))
		else $error("search index beyond list");

	a_xfer_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		evt_xfer |=> (state_q == ST_SEARCH) || (state_q == ST_DONE))
		else $error("event transfer did not start the sequencer");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> res_valid_q)
		else $error("result not presented after load");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for recent_id_dedup_event_counter: directed table, then random event phases.
// Checks every result against table values or an in-bench move-to-front and saturating counter predictor.
// Depends on rdec_pkg and the recent_id_dedup_event_counter RTL.

module tb_top;
	import rdec_pkg::*;

	localparam int TRADE_LIST = 0;
	localparam int BATTLE_LIST = 1;
	localparam int POOL_SIZE = 10;
	localparam int PHASES = 8;
	localparam int PHASE_EVENTS = 94;

	typedef struct {
		logic                  set_cfg;
		logic                  en;
		logic                  cnt;
		logic [CFG_DATA_W-1:0] lim;
		evt_t                  ev;
		logic                  typed;
		res_t                  want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic evt_valid = 1'b0;
	logic evt_stall;
	evt_t evt = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic quiet = 1'b0;
	int unsigned stall_left = 0;
	int mismatches = 0;

	logic [ID_W-1:0] recent_ids [2][LIST_DEPTH];
	logic [CNT_W-1:0] win_cnt = '0;
	logic [CNT_W-1:0] loss_cnt = '0;
	logic [CNT_W-1:0] trade_cnt = '0;
	logic en_q = 1'b0;
	logic count_q = 1'b0;
	logic [CNT_W-1:0] limit_q = STAT_LIMIT_RST;
	logic [ID_W-1:0] id_pool [POOL_SIZE];
	res_t pending_totals [$];

	recent_id_dedup_event_counter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic logic [CNT_W-1:0] sat_incr(logic [CNT_W-1:0] c);
		logic [CNT_W:0] nxt;
		nxt = {1'b0, c} + 1'b1;
		if (nxt > {1'b0, limit_q})
			nxt = {1'b0, limit_q};
		return nxt[CNT_W-1:0];
	endfunction

	function automatic res_t tally_event(evt_t ev);
		res_t r;
		int pos;
		int sel;
		int top;
		logic miss;
		r = '0;
		pos = LIST_DEPTH;
		if (en_q && ev.mode != MODE_INVALID) begin
			sel = (ev.mode == MODE_TRADE) ? TRADE_LIST : BATTLE_LIST;
			for (int k = LIST_DEPTH - 1; k >= 0; k--)
				if (recent_ids[sel][k] == ev.partner_id)
					pos = k;
			miss = (pos == LIST_DEPTH);
			top = miss ? LIST_DEPTH - 1 : pos;
			for (int k = top; k > 0; k--)
				recent_ids[sel][k] = recent_ids[sel][k-1];
			recent_ids[sel][0] = ev.partner_id;
			if (miss) begin
				r.is_new = 1'b1;
				if (count_q) begin
					case (ev.mode)
						MODE_TRADE: trade_cnt = sat_incr(trade_cnt);
						MODE_WIN: win_cnt = sat_incr(win_cnt);
						default: loss_cnt = sat_incr(loss_cnt);
					endcase
					r.counted = 1'b1;
				end
			end
		end
		r.win_total = win_cnt;
		r.loss_total = loss_cnt;
		r.trade_total = trade_cnt;
		return r;
	endfunction

	function automatic row_t seen(logic [1:0] m, logic [ID_W-1:0] id);
		row_t r;
		r = '{default: '0};
		r.ev.mode = m;
		r.ev.partner_id = id;
		return r;
	endfunction

	function automatic row_t known(logic [1:0] m, logic [ID_W-1:0] id, logic n, logic c,
			logic [CNT_W-1:0] w, logic [CNT_W-1:0] l, logic [CNT_W-1:0] t);
		row_t r;
		r = seen(m, id);
		r.typed = 1'b1;
		r.want.is_new = n;
		r.want.counted = c;
		r.want.win_total = w;
		r.want.loss_total = l;
		r.want.trade_total = t;
		return r;
	endfunction

	function automatic row_t setting(logic en, logic cnt, logic [CFG_DATA_W-1:0] lim);
		row_t r;
		r = '{default: '0};
		r.set_cfg = 1'b1;
		r.en = en;
		r.cnt = cnt;
		r.lim = lim;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic evt_t random_event();
		evt_t ev;
		int r;
		ev.mode = ($urandom_range(0, 9) == 0) ? MODE_INVALID : 2'($urandom_range(0, 2));
		r = $urandom_range(0, 99);
		if (r < 85)
			ev.partner_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
		else if (r < 95)
			ev.partner_id = $urandom;
		else
			ev.partner_id = '0;
		return ev;
	endfunction

	task automatic report_mismatch(string msg);
		$display("ERROR @%0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	task automatic send_event(evt_t ev, res_t want, int gap);
		if (gap > 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_valid <= 1'b1;
		evt <= ev;
		@(posedge clk);
		while (evt_stall)
			@(posedge clk);
		pending_totals.push_back(want);
	endtask

	task automatic settle();
		evt_valid <= 1'b0;
		while (pending_totals.size() != 0)
			@(posedge clk);
	endtask

	task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic write_settings(logic en, logic cnt, logic [CFG_DATA_W-1:0] lim);
		put_reg(REG_STATS_EN, {{(CFG_DATA_W-1){1'b0}}, en});
		put_reg(REG_CARD_COUNT, {{(CFG_DATA_W-1){1'b0}}, cnt});
		put_reg(REG_STAT_LIMIT, lim);
		cfg_we <= 1'b0;
		en_q = en;
		count_q = cnt;
		limit_q = lim;
	endtask

	always @(posedge clk) begin
		if (stall_left != 0)
			stall_left <= stall_left - 1;
		else if (quiet)
			res_stall <= 1'b0;
		else if ($urandom_range(0, 9) < 6) begin
			res_stall <= 1'b0;
			stall_left <= $urandom_range(0, 8);
		end else if ($urandom_range(0, 9) != 0) begin
			res_stall <= 1'b1;
			stall_left <= $urandom_range(0, 2);
		end else begin
			res_stall <= 1'b1;
			stall_left <= $urandom_range(10, 40);
		end
	end

	always @(posedge clk) begin : watch_results
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_totals.size() == 0)
				report_mismatch("result transfer with nothing pending");
			else begin
				want = pending_totals.pop_front();
				check_field("is_new", res.is_new, want.is_new);
				check_field("counted", res.counted, want.counted);
				check_field("win_total", res.win_total, want.win_total);
				check_field("loss_total", res.loss_total, want.loss_total);
				check_field("trade_total", res.trade_total, want.trade_total);
			end
		end
	end

	initial begin : stimulus
		row_t plan [$];
		evt_t ev;
		res_t want;
		for (int s = 0; s < 2; s++)
			for (int k = 0; k < LIST_DEPTH; k++)
				recent_ids[s][k] = '0;

		plan.push_back(known(MODE_TRADE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
		plan.push_back(known(MODE_WIN, 32'h0000_0000, 0, 0, 0, 0, 0));
		plan.push_back(known(MODE_INVALID, 32'h5A5A_5A5A, 0, 0, 0, 0, 0));
		plan.push_back(setting(1, 0, 16'd999));
		plan.push_back(known(MODE_TRADE, 32'h0000_0000, 0, 0, 0, 0, 0));
		plan.push_back(known(MODE_TRADE, 32'hFFFF_FFFF, 1, 0, 0, 0, 0));
		plan.push_back(known(MODE_LOSS, 32'hFFFF_FFFF, 1, 0, 0, 0, 0));
		plan.push_back(setting(1, 1, 16'd1));
		plan.push_back(known(MODE_WIN, 32'hAAAA_AAAA, 1, 1, 1, 0, 0));
		plan.push_back(known(MODE_WIN, 32'h5555_5555, 1, 1, 1, 0, 0));
		plan.push_back(seen(MODE_LOSS, 32'hAAAA_AAAA));
		plan.push_back(known(MODE_LOSS, 32'h1234_5678, 1, 1, 1, 1, 0));
		plan.push_back(known(MODE_INVALID, 32'h8765_4321, 0, 0, 1, 1, 0));
		plan.push_back(known(MODE_TRADE, 32'h0000_0001, 1, 1, 1, 1, 1));
		plan.push_back(setting(1, 1, 16'd0));
		plan.push_back(known(MODE_TRADE, 32'h0000_0002, 1, 1, 1, 1, 0));
		plan.push_back(known(MODE_WIN, 32'hFFFF_0000, 1, 1, 0, 1, 0));
		plan.push_back(setting(1, 1, 16'hFFFF));
		plan.push_back(seen(MODE_WIN, 32'h0000_0000));
		plan.push_back(seen(MODE_LOSS, 32'hFFFF_FFFF));
		plan.push_back(seen(MODE_TRADE, 32'h0000_0000));
		plan.push_back(seen(MODE_WIN, 32'h0000_FFFF));
		plan.push_back(setting(0, 1, 16'hFFFF));
		plan.push_back(known(MODE_WIN, 32'h0000_FFFF, 0, 0, 1, 1, 0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < plan.size(); i++) begin
			if (plan[i].set_cfg) begin
				settle();
				write_settings(plan[i].en, plan[i].cnt, plan[i].lim);
			end else begin
				want = tally_event(plan[i].ev);
				if (plan[i].typed)
					want = plan[i].want;
				send_event(plan[i].ev, want, pick_gap());
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: write_settings(1'b1, 1'b1, 16'hFFFF);
				1: write_settings(1'b1, 1'b1, 16'd3);
				2: write_settings(1'b1, 1'b0, CFG_DATA_W'($urandom));
				3: write_settings(1'b0, 1'b1, CFG_DATA_W'($urandom));
				4: write_settings(1'b1, 1'b1, 16'd0);
				default: write_settings($urandom_range(0, 5) != 0, $urandom_range(0, 3) != 0,
					CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(1, 12) : $urandom));
			endcase
			quiet = (p % 3 == 2);
			for (int k = 0; k < POOL_SIZE; k++)
				id_pool[k] = $urandom;
			if ($urandom_range(0, 1))
				id_pool[0] = '0;
			repeat (PHASE_EVENTS) begin
				ev = random_event();
				want = tally_event(ev);
				send_event(ev, want, pick_gap());
			end
		end

		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/rdec_pkg.sv
rtl/core/recent_id_dedup_event_counter.sv
verif/tb_top.sv
